>>> rtl/tdse_pkg.sv
// Package for the tagged data stack engine: codes, entry layout and the shuffle table.
package tdse_pkg;

    localparam int VALUE_W = 64;
    localparam int TAG_W   = 3;
    localparam int ENTRY_W = VALUE_W + TAG_W;

    typedef enum logic [4:0] {
        OP_PUSH  = 5'd0,
        OP_DUP   = 5'd1,
        OP_DUPD  = 5'd2,
        OP_DUP2  = 5'd3,
        OP_SWAP  = 5'd4,
        OP_SWAPD = 5'd5,
        OP_SWAP2 = 5'd6,
        OP_OVER  = 5'd7,
        OP_OVERD = 5'd8,
        OP_OVER2 = 5'd9,
        OP_NIP   = 5'd10,
        OP_NIPD  = 5'd11,
        OP_DROP  = 5'd12,
        OP_DROP2 = 5'd13,
        OP_ROT   = 5'd14,
        OP_TUCK  = 5'd15,
        OP_PICK  = 5'd16,
        OP_ROLL  = 5'd17,
        OP_CLEAR = 5'd18,
        OP_DEPTH = 5'd19
    } op_t;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_UNDER  = 3'd1,
        ST_OVER   = 3'd2,
        ST_NOTINT = 3'd3,
        ST_NEG    = 3'd4,
        ST_RANGE  = 3'd5
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_LD_RD,
        S_LD_CAP,
        S_WR,
        S_INDEX,
        S_PK_RD,
        S_PK_CAP,
        S_RL_RD,
        S_RL_SAVE,
        S_RL_STEP,
        S_RL_MOVE,
        S_TOP_RD,
        S_TOP_CAP,
        S_DONE
    } state_t;

    // One result item as handed from the engine to the output register.
    typedef struct packed {
        status_t     status;
        logic [8:0]  depth;
        logic        empty;
        logic [63:0] value;
        logic [1:0]  tag;
        logic        taint;
    } res_t;

    // Shuffle word: consume need top entries, push len entries bottom to top.
    // Entry k of src sits in bits [2k+1:2k] and names its old depth from the top.
    typedef struct packed {
        logic [2:0]  need;
        logic [2:0]  len;
        logic [11:0] src;
    } shuf_t;

    function automatic shuf_t shuffle_of(input logic [4:0] op);
        shuf_t s;
        s = '0;
        case (op)
            OP_DUP:   s = '{3'd1, 3'd2, {2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0}};
            OP_DUPD:  s = '{3'd2, 3'd3, {2'd0, 2'd0, 2'd0, 2'd0, 2'd1, 2'd1}};
            OP_DUP2:  s = '{3'd2, 3'd4, {2'd0, 2'd0, 2'd0, 2'd1, 2'd0, 2'd1}};
            OP_SWAP:  s = '{3'd2, 3'd2, {2'd0, 2'd0, 2'd0, 2'd0, 2'd1, 2'd0}};
            OP_SWAPD: s = '{3'd3, 3'd3, {2'd0, 2'd0, 2'd0, 2'd0, 2'd2, 2'd1}};
            OP_SWAP2: s = '{3'd4, 3'd4, {2'd0, 2'd0, 2'd2, 2'd3, 2'd0, 2'd1}};
            OP_OVER:  s = '{3'd2, 3'd3, {2'd0, 2'd0, 2'd0, 2'd1, 2'd0, 2'd1}};
            OP_OVERD: s = '{3'd3, 3'd4, {2'd0, 2'd0, 2'd0, 2'd2, 2'd1, 2'd2}};
            OP_OVER2: s = '{3'd4, 3'd6, {2'd2, 2'd3, 2'd0, 2'd1, 2'd2, 2'd3}};
            OP_NIP:   s = '{3'd2, 3'd1, {2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0}};
            OP_NIPD:  s = '{3'd3, 3'd2, {2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd2}};
            OP_DROP:  s = '{3'd1, 3'd0, 12'd0};
            OP_DROP2: s = '{3'd2, 3'd0, 12'd0};
            OP_ROT:   s = '{3'd3, 3'd3, {2'd0, 2'd0, 2'd0, 2'd2, 2'd0, 2'd1}};
            OP_TUCK:  s = '{3'd2, 3'd3, {2'd0, 2'd0, 2'd0, 2'd0, 2'd1, 2'd0}};
            default:  s = '0;
        endcase
        return s;
    endfunction

endpackage

>>> rtl/tdse_mem.sv
// Stack entry memory: one write port, one read port with registered read data.
module tdse_mem #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic                         clk,
    input  logic                         we,
    input  logic [AW-1:0]                waddr,
    input  logic [tdse_pkg::ENTRY_W-1:0] wdata,
    input  logic [AW-1:0]                raddr,
    output logic [tdse_pkg::ENTRY_W-1:0] rdata
);

    logic [tdse_pkg::ENTRY_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/tdse_engine.sv
// Stack sequencer: checks, loads, shuffles and walks the stack through one memory port pair.
module tdse_engine #(
    parameter int STACK_DEPTH = 256,
    parameter int AW          = 8,
    parameter int CW          = 9
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req_valid,
    output logic                         req_ready,
    input  logic [4:0]                   req_op,
    input  logic [63:0]                  req_value,
    input  logic [1:0]                   req_tag,
    input  logic                         req_taint,
    output logic                         res_valid,
    input  logic                         res_ready,
    output tdse_pkg::res_t               res,
    output logic                         mem_we,
    output logic [AW-1:0]                mem_waddr,
    output logic [tdse_pkg::ENTRY_W-1:0] mem_wdata,
    output logic [AW-1:0]                mem_raddr,
    input  logic [tdse_pkg::ENTRY_W-1:0] mem_rdata
);

    localparam logic [CW:0] DEPTH_C = (CW+1)'(STACK_DEPTH);

    tdse_pkg::state_t  state_reg, state_next;
    tdse_pkg::status_t status_reg, status_next;
    tdse_pkg::res_t    res_reg, res_next;

    logic [4:0]                   op_reg, op_next;
    logic [63:0]                  pv_reg, pv_next;
    logic [2:0]                   pt_reg, pt_next;
    logic [CW-1:0]                count_reg, count_next;
    logic [2:0]                   k_reg, k_next;
    logic [AW-1:0]                ptr_reg, ptr_next;
    logic [tdse_pkg::ENTRY_W-1:0] tv_reg [4];
    logic [tdse_pkg::ENTRY_W-1:0] tv_next [4];

    tdse_pkg::shuf_t sh;
    logic            is_index_op;
    logic [2:0]      ld_need;
    logic [CW:0]     after_sh;
    logic [CW-1:0]   ld_addr;
    logic [CW-1:0]   wr_addr;
    logic [CW-1:0]   rest;
    logic [CW-1:0]   hi;
    logic [CW-1:0]   lo;
    logic [CW-1:0]   top_addr;
    logic [63:0]     n_val;
    logic            n_ge_rest;
    logic [1:0]      src_k;
    logic [CW+8:0]   depth_ext;

    always_comb
    begin
        sh          = tdse_pkg::shuffle_of(op_reg);
        is_index_op = (op_reg == tdse_pkg::OP_PICK) || (op_reg == tdse_pkg::OP_ROLL);
        ld_need     = is_index_op ? 3'd1 : sh.need;
        after_sh    = {1'b0, count_reg} - (CW+1)'(sh.need) + (CW+1)'(sh.len);
        ld_addr     = count_reg - CW'(1) - CW'(k_reg);
        wr_addr     = count_reg - CW'(sh.need) + CW'(k_reg);
        rest        = count_reg - CW'(1);
        hi          = count_reg - CW'(2);
        n_val       = tv_reg[0][63:0];
        n_ge_rest   = n_val >= 64'(rest);
        lo          = hi - n_val[CW-1:0];
        top_addr    = count_reg - CW'(1);
        src_k       = sh.src[2*k_reg +: 2];
        depth_ext   = {9'd0, count_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tdse_pkg::S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        res_reg    <= res_next;
        op_reg     <= op_next;
        pv_reg     <= pv_next;
        pt_reg     <= pt_next;
        k_reg      <= k_next;
        ptr_reg    <= ptr_next;
        tv_reg     <= tv_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        status_next = status_reg;
        res_next    = res_reg;
        op_next     = op_reg;
        pv_next     = pv_reg;
        pt_next     = pt_reg;
        count_next  = count_reg;
        k_next      = k_reg;
        ptr_next    = ptr_reg;
        tv_next     = tv_reg;
        mem_we      = 1'b0;
        mem_waddr   = top_addr[AW-1:0];
        mem_wdata   = tv_reg[0];
        mem_raddr   = top_addr[AW-1:0];
        req_ready   = 1'b0;
        res_valid   = 1'b0;

        unique case (state_reg)
            tdse_pkg::S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    op_next     = req_op;
                    pv_next     = req_value;
                    pt_next     = {req_taint, req_tag};
                    status_next = tdse_pkg::ST_OK;
                    k_next      = '0;
                    state_next  = tdse_pkg::S_CHECK;
                end
            end

            tdse_pkg::S_CHECK:
            begin
                state_next = tdse_pkg::S_TOP_RD;
                case (op_reg) inside
                    tdse_pkg::OP_PUSH, tdse_pkg::OP_DEPTH:
                    begin
                        if ({1'b0, count_reg} >= DEPTH_C)
                        begin
                            status_next = tdse_pkg::ST_OVER;
                        end
                        else
                        begin
                            mem_we     = 1'b1;
                            mem_waddr  = count_reg[AW-1:0];
                            mem_wdata  = (op_reg == tdse_pkg::OP_PUSH) ?
                                         {pt_reg, pv_reg} : {3'd0, 64'(count_reg)};
                            count_next = count_reg + CW'(1);
                        end
                    end
                    tdse_pkg::OP_PICK, tdse_pkg::OP_ROLL:
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = tdse_pkg::ST_UNDER;
                        end
                        else
                        begin
                            state_next = tdse_pkg::S_LD_RD;
                        end
                    end
                    tdse_pkg::OP_CLEAR:
                    begin
                        count_next = '0;
                    end
                    default:
                    begin
                        // shuffles; codes without a shuffle have need zero and fall through
                        if (sh.need != 3'd0)
                        begin
                            if (count_reg < CW'(sh.need))
                            begin
                                status_next = tdse_pkg::ST_UNDER;
                            end
                            else if (after_sh > DEPTH_C)
                            begin
                                status_next = tdse_pkg::ST_OVER;
                            end
                            else
                            begin
                                state_next = tdse_pkg::S_LD_RD;
                            end
                        end
                    end
                endcase
            end

            tdse_pkg::S_LD_RD:
            begin
                mem_raddr  = ld_addr[AW-1:0];
                state_next = tdse_pkg::S_LD_CAP;
            end

            tdse_pkg::S_LD_CAP:
            begin
                tv_next[k_reg[1:0]] = mem_rdata;
                if (k_reg == ld_need - 3'd1)
                begin
                    k_next     = '0;
                    state_next = is_index_op ? tdse_pkg::S_INDEX : tdse_pkg::S_WR;
                end
                else
                begin
                    k_next     = k_reg + 3'd1;
                    state_next = tdse_pkg::S_LD_RD;
                end
            end

            tdse_pkg::S_WR:
            begin
                mem_waddr = wr_addr[AW-1:0];
                mem_wdata = tv_reg[src_k];
                mem_we    = (k_reg < sh.len);
                if (({1'b0, k_reg} + 4'd1) >= {1'b0, sh.len})
                begin
                    count_next = count_reg - CW'(sh.need) + CW'(sh.len);
                    state_next = tdse_pkg::S_TOP_RD;
                end
                else
                begin
                    k_next = k_reg + 3'd1;
                end
            end

            tdse_pkg::S_INDEX:
            begin
                state_next = tdse_pkg::S_TOP_RD;
                if (tv_reg[0][65:64] != 2'd0)
                begin
                    status_next = tdse_pkg::ST_NOTINT;
                end
                else if (n_val[63])
                begin
                    status_next = tdse_pkg::ST_NEG;
                end
                else if (op_reg == tdse_pkg::OP_PICK)
                begin
                    if (n_ge_rest)
                    begin
                        status_next = tdse_pkg::ST_RANGE;
                    end
                    else
                    begin
                        state_next = tdse_pkg::S_PK_RD;
                    end
                end
                else if (n_val == 64'd0)
                begin
                    count_next = rest;
                end
                else if (n_ge_rest)
                begin
                    status_next = tdse_pkg::ST_RANGE;
                end
                else
                begin
                    ptr_next   = lo[AW-1:0];
                    state_next = tdse_pkg::S_RL_RD;
                end
            end

            tdse_pkg::S_PK_RD:
            begin
                mem_raddr  = lo[AW-1:0];
                state_next = tdse_pkg::S_PK_CAP;
            end

            tdse_pkg::S_PK_CAP:
            begin
                // overwrite the index slot with the picked entry
                mem_we     = 1'b1;
                mem_waddr  = top_addr[AW-1:0];
                mem_wdata  = mem_rdata;
                state_next = tdse_pkg::S_TOP_RD;
            end

            tdse_pkg::S_RL_RD:
            begin
                mem_raddr  = ptr_reg;
                state_next = tdse_pkg::S_RL_SAVE;
            end

            tdse_pkg::S_RL_SAVE:
            begin
                tv_next[1] = mem_rdata;
                state_next = tdse_pkg::S_RL_STEP;
            end

            tdse_pkg::S_RL_STEP:
            begin
                if (ptr_reg == hi[AW-1:0])
                begin
                    // drop the saved entry on the new top and pop the index
                    mem_we     = 1'b1;
                    mem_waddr  = ptr_reg;
                    mem_wdata  = tv_reg[1];
                    count_next = rest;
                    state_next = tdse_pkg::S_TOP_RD;
                end
                else
                begin
                    mem_raddr  = ptr_reg + AW'(1);
                    state_next = tdse_pkg::S_RL_MOVE;
                end
            end

            tdse_pkg::S_RL_MOVE:
            begin
                mem_we     = 1'b1;
                mem_waddr  = ptr_reg;
                mem_wdata  = mem_rdata;
                ptr_next   = ptr_reg + AW'(1);
                state_next = tdse_pkg::S_RL_STEP;
            end

            tdse_pkg::S_TOP_RD:
            begin
                res_next.status = status_reg;
                res_next.depth  = depth_ext[8:0];
                res_next.empty  = (count_reg == '0);
                res_next.value  = '0;
                res_next.tag    = '0;
                res_next.taint  = 1'b0;
                if (count_reg == '0)
                begin
                    state_next = tdse_pkg::S_DONE;
                end
                else
                begin
                    mem_raddr  = top_addr[AW-1:0];
                    state_next = tdse_pkg::S_TOP_CAP;
                end
            end

            tdse_pkg::S_TOP_CAP:
            begin
                res_next.value = mem_rdata[63:0];
                res_next.tag   = mem_rdata[65:64];
                res_next.taint = mem_rdata[66];
                state_next     = tdse_pkg::S_DONE;
            end

            tdse_pkg::S_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = tdse_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = tdse_pkg::S_IDLE;
            end
        endcase
    end

    assign res = res_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, count_reg} <= DEPTH_C)
        else $error("stack count above depth");

    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (int'(mem_waddr) < STACK_DEPTH))
        else $error("memory write beyond stack depth");

    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tdse_pkg::S_IDLE || state_reg == tdse_pkg::S_DONE) |-> !mem_we)
        else $error("memory write outside an operation");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> (res_valid && $stable(res_reg) && $stable(count_reg)))
        else $error("pending result changed");

    a_error_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tdse_pkg::S_INDEX && status_next != tdse_pkg::ST_OK)
        |=> $stable(count_reg))
        else $error("count changed on index error");

endmodule

>>> rtl/tagged_data_stack_engine_top.sv
// Top level of the tagged data stack engine: output register and instances.
//
// Input channel: in_valid / in_stall with operation, push_value, push_tag and
// push_taint. A request is taken at a rising edge with in_valid high and
// in_stall low. in_stall stays high while an operation is in progress.
// Output channel: out_valid / out_stall with status, depth, stack_empty and the
// top element fields; exactly one result per request, in order.
// Each request is served by the sequencer through the single memory port pair:
//   push, depth, clear, unknown codes and any error found before a load:
//   at most one write, then the read of the new top
//   shuffles: load need entries, write len entries, read the new top,
//   need up to 4 and len up to 6
//   pick and roll: load the index, then check it; pick copies the deep entry,
//   roll with index 0 only pops, roll with index n walks n entries
// A finished result sits in the output register; the next request is taken
// while it waits, and its result is held inside until the register frees.
// While the receiver stalls, out_valid and the result fields hold.
// Reset clears the element count and all handshake state at once; the
// memory needs no clearing pass since only entries below the count are read.
module tagged_data_stack_engine_top #(
    parameter int STACK_DEPTH = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [4:0]         operation,
    input  logic signed [63:0] push_value,
    input  logic [1:0]         push_tag,
    input  logic               push_taint,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         status,
    output logic [8:0]         depth,
    output logic               stack_empty,
    output logic signed [63:0] top_value,
    output logic [1:0]         top_tag,
    output logic               top_taint
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);

    logic                         req_ready;
    logic                         res_valid;
    logic                         res_ready;
    tdse_pkg::res_t               res;
    logic                         mem_we;
    logic [AW-1:0]                mem_waddr;
    logic [tdse_pkg::ENTRY_W-1:0] mem_wdata;
    logic [AW-1:0]                mem_raddr;
    logic [tdse_pkg::ENTRY_W-1:0] mem_rdata;

    logic           out_valid_reg, out_valid_next;
    tdse_pkg::res_t out_reg;
    logic           load;

    tdse_engine #(
        .STACK_DEPTH (STACK_DEPTH),
        .AW          (AW),
        .CW          (CW)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (in_valid),
        .req_ready (req_ready),
        .req_op    (operation),
        .req_value (push_value),
        .req_tag   (push_tag),
        .req_taint (push_taint),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    tdse_mem #(
        .DEPTH (STACK_DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Take a new result when the register is empty or draining this cycle.
    assign res_ready = !out_valid_reg || !out_stall;
    assign load      = res_valid && res_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_reg <= res;
        end
    end

    assign in_stall    = !req_ready;
    assign out_valid   = out_valid_reg;
    assign status      = out_reg.status;
    assign depth       = out_reg.depth;
    assign stack_empty = out_reg.empty;
    assign top_value   = signed'(out_reg.value);
    assign top_tag     = out_reg.tag;
    assign top_taint   = out_reg.taint;

endmodule

>>> tb/stack_result_checker.sv
// Checker for the tagged data stack engine: predicts each result and compares.
module stack_result_checker #(
    parameter int STACK_DEPTH = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [4:0]         operation,
    input  logic signed [63:0] push_value,
    input  logic [1:0]         push_tag,
    input  logic               push_taint,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic [2:0]         status,
    input  logic [8:0]         depth,
    input  logic               stack_empty,
    input  logic signed [63:0] top_value,
    input  logic [1:0]         top_tag,
    input  logic               top_taint,
    output int                 pending,
    output int                 failures
);

    typedef struct {
        tdse_pkg::status_t st;
        logic [8:0]        depth;
        logic              empty;
        logic [63:0]       value;
        logic [1:0]        tag;
        logic              taint;
    } stack_result_t;

    logic [63:0]   slot_value [STACK_DEPTH];
    logic [2:0]    slot_tag   [STACK_DEPTH];
    int            held;
    stack_result_t expected_results [$];

    // Run one request against the shadow stack and report its outcome.
    task automatic apply_stack_op(
        input  logic [4:0]     op,
        input  logic [63:0]    pv,
        input  logic [1:0]     pt,
        input  logic           pk,
        output stack_result_t  r
    );
        tdse_pkg::status_t st;
        int          need;
        int          len;
        int          i;
        int          rest;
        int          lo;
        int          hi;
        int          src [6];
        logic [63:0] took_v [4];
        logic [2:0]  took_t [4];
        logic [63:0] idx;
        logic [63:0] mv;
        logic [2:0]  mt;
        st = tdse_pkg::ST_OK;
        need = 0;
        len = 0;
        src = '{0, 0, 0, 0, 0, 0};
        if (op == tdse_pkg::OP_PUSH || op == tdse_pkg::OP_DEPTH)
        begin
            if (held >= STACK_DEPTH)
                st = tdse_pkg::ST_OVER;
            else
            begin
                slot_value[held] = (op == tdse_pkg::OP_PUSH) ? pv : 64'(held);
                slot_tag[held]   = (op == tdse_pkg::OP_PUSH) ? {pk, pt} : 3'd0;
                held++;
            end
        end
        else if (op >= tdse_pkg::OP_DUP && op <= tdse_pkg::OP_TUCK)
        begin
            // src lists the new entries bottom to top by old depth from the top
            case (op)
                tdse_pkg::OP_DUP:   begin need = 1; len = 2; src = '{0, 0, 0, 0, 0, 0}; end
                tdse_pkg::OP_DUPD:  begin need = 2; len = 3; src = '{1, 1, 0, 0, 0, 0}; end
                tdse_pkg::OP_DUP2:  begin need = 2; len = 4; src = '{1, 0, 1, 0, 0, 0}; end
                tdse_pkg::OP_SWAP:  begin need = 2; len = 2; src = '{0, 1, 0, 0, 0, 0}; end
                tdse_pkg::OP_SWAPD: begin need = 3; len = 3; src = '{1, 2, 0, 0, 0, 0}; end
                tdse_pkg::OP_SWAP2: begin need = 4; len = 4; src = '{1, 0, 3, 2, 0, 0}; end
                tdse_pkg::OP_OVER:  begin need = 2; len = 3; src = '{1, 0, 1, 0, 0, 0}; end
                tdse_pkg::OP_OVERD: begin need = 3; len = 4; src = '{2, 1, 2, 0, 0, 0}; end
                tdse_pkg::OP_OVER2: begin need = 4; len = 6; src = '{3, 2, 1, 0, 3, 2}; end
                tdse_pkg::OP_NIP:   begin need = 2; len = 1; src = '{0, 0, 0, 0, 0, 0}; end
                tdse_pkg::OP_NIPD:  begin need = 3; len = 2; src = '{2, 0, 0, 0, 0, 0}; end
                tdse_pkg::OP_DROP:  begin need = 1; len = 0; end
                tdse_pkg::OP_DROP2: begin need = 2; len = 0; end
                tdse_pkg::OP_ROT:   begin need = 3; len = 3; src = '{1, 0, 2, 0, 0, 0}; end
                default:            begin need = 2; len = 3; src = '{0, 1, 0, 0, 0, 0}; end
            endcase
            if (held < need)
                st = tdse_pkg::ST_UNDER;
            else if (held - need + len > STACK_DEPTH)
                st = tdse_pkg::ST_OVER;
            else
            begin
                for (i = 0; i < need; i++)
                begin
                    took_v[i] = slot_value[held - 1 - i];
                    took_t[i] = slot_tag[held - 1 - i];
                end
                held -= need;
                for (i = 0; i < len; i++)
                begin
                    slot_value[held] = took_v[src[i]];
                    slot_tag[held]   = took_t[src[i]];
                    held++;
                end
            end
        end
        else if (op == tdse_pkg::OP_PICK || op == tdse_pkg::OP_ROLL)
        begin
            if (held < 1)
                st = tdse_pkg::ST_UNDER;
            else if (slot_tag[held - 1][1:0] != 2'd0)
                st = tdse_pkg::ST_NOTINT;
            else if (slot_value[held - 1][63])
                st = tdse_pkg::ST_NEG;
            else
            begin
                idx  = slot_value[held - 1];
                rest = held - 1;
                if (op == tdse_pkg::OP_PICK)
                begin
                    if (idx >= 64'(rest))
                        st = tdse_pkg::ST_RANGE;
                    else
                    begin
                        slot_value[held - 1] = slot_value[rest - 1 - int'(idx)];
                        slot_tag[held - 1]   = slot_tag[rest - 1 - int'(idx)];
                    end
                end
                else if (idx != 64'd0 && idx >= 64'(rest))
                    st = tdse_pkg::ST_RANGE;
                else
                begin
                    held = rest;
                    if (idx != 64'd0)
                    begin
                        // lift the deep entry to the top, shift the rest down
                        lo = rest - 1 - int'(idx);
                        hi = rest - 1;
                        mv = slot_value[lo];
                        mt = slot_tag[lo];
                        for (i = lo; i < hi; i++)
                        begin
                            slot_value[i] = slot_value[i + 1];
                            slot_tag[i]   = slot_tag[i + 1];
                        end
                        slot_value[hi] = mv;
                        slot_tag[hi]   = mt;
                    end
                end
            end
        end
        else if (op == tdse_pkg::OP_CLEAR)
            held = 0;

        r.st    = st;
        r.depth = 9'(held);
        r.empty = (held == 0);
        if (held == 0)
        begin
            r.value = '0;
            r.tag   = '0;
            r.taint = 1'b0;
        end
        else
        begin
            r.value = slot_value[held - 1];
            r.tag   = slot_tag[held - 1][1:0];
            r.taint = slot_tag[held - 1][2];
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            failures++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        stack_result_t want;
        stack_result_t next;
        if (!rst_n)
        begin
            held = 0;
            expected_results.delete();
            pending  = 0;
            failures = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: result with no request waiting, status %0d depth %0d",
                             $time, status, depth);
                    failures++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("status", 64'(want.st), 64'(status));
                    check_field("depth", 64'(want.depth), 64'(depth));
                    check_field("stack_empty", 64'(want.empty), 64'(stack_empty));
                    check_field("top_value", want.value, top_value);
                    check_field("top_tag", 64'(want.tag), 64'(top_tag));
                    check_field("top_taint", 64'(want.taint), 64'(top_taint));
                end
            end
            if (in_valid && !in_stall)
            begin
                apply_stack_op(operation, push_value, push_tag, push_taint, next);
                expected_results.push_back(next);
            end
            pending = expected_results.size();
        end
    end

endmodule

>>> tb/tb_tagged_data_stack_engine_top.sv
// Testbench top for the tagged data stack engine: clock, reset, requests and verdict.
module tb_tagged_data_stack_engine_top;

    localparam int         STACK_DEPTH     = 256;
    localparam int         ITEM_TARGET     = 1500;
    localparam int         FILL_SPACING    = 500;
    localparam logic [4:0] OP_UNUSED_FIRST = 5'd20;
    localparam logic [4:0] OP_UNUSED_LAST  = 5'd31;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [4:0]         operation;
    logic signed [63:0] push_value;
    logic [1:0]         push_tag;
    logic               push_taint;
    logic               out_valid;
    logic               out_stall;
    logic [2:0]         status;
    logic [8:0]         depth;
    logic               stack_empty;
    logic signed [63:0] top_value;
    logic [1:0]         top_tag;
    logic               top_taint;
    int                 pending_results;
    int                 mismatch_count;

    int requests_sent;
    int burst_left;

    tagged_data_stack_engine_top #(.STACK_DEPTH(STACK_DEPTH)) dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .operation(operation), .push_value(push_value),
        .push_tag(push_tag), .push_taint(push_taint),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .depth(depth), .stack_empty(stack_empty),
        .top_value(top_value), .top_tag(top_tag), .top_taint(top_taint)
    );

    stack_result_checker #(.STACK_DEPTH(STACK_DEPTH)) u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .operation(operation), .push_value(push_value),
        .push_tag(push_tag), .push_taint(push_taint),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .depth(depth), .stack_empty(stack_empty),
        .top_value(top_value), .top_tag(top_tag), .top_taint(top_taint),
        .pending(pending_results), .failures(mismatch_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #40_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // Receiver: switch between four stall patterns, from never to mostly stalling, each for a random span.
    initial
    begin : receiver_stall
        int mode;
        int span;
        out_stall = 1'b0;
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 200);
            repeat (span)
            begin
                @(negedge clk);
                case (mode)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= ($urandom_range(0, 3) == 0);
                    2:       out_stall <= ($urandom_range(0, 1) == 0);
                    default: out_stall <= ($urandom_range(0, 9) < 8);
                endcase
            end
        end
    end

    task automatic send_request(input logic [4:0] op, input logic [63:0] v,
                                input logic [1:0] t, input logic k);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        in_valid   <= 1'b1;
        operation  <= op;
        push_value <= v;
        push_tag   <= t;
        push_taint <= k;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        if (op < OP_UNUSED_FIRST)
            requests_sent++;
    endtask

    // Hold off until every result is back.
    task automatic pause_until_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        burst_left = 0;
        while (pending_results != 0) @(negedge clk);
    endtask

    function automatic logic [63:0] random_payload();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0:       return 64'h7FFF_FFFF_FFFF_FFFF;
            1:       return 64'h8000_0000_0000_0000;
            2:       return 64'd0;
            3:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [63:0] index_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 64'($urandom_range(0, 7));
        else if (r < 75)
            return 64'($urandom_range(0, 40));
        else if (r < 85)
            return 64'($urandom_range(0, 300));
        else if (r < 92)
            return {1'b1, 31'($urandom), $urandom};
        else
            return {1'b0, 31'($urandom), $urandom};
    endfunction

    // Push an index, then pick or roll with it.
    task automatic indexed_access();
        logic [1:0] t;
        t = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(1, 3)) : 2'd0;
        send_request(tdse_pkg::OP_PUSH, index_value(), t, 1'($urandom));
        send_request($urandom_range(0, 1) ? tdse_pkg::OP_PICK : tdse_pkg::OP_ROLL,
                     random_payload(), 2'($urandom), 1'($urandom));
    endtask

    task automatic churn_step();
        int         r;
        logic [1:0] t;
        r = $urandom_range(0, 99);
        t = ($urandom_range(0, 7) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
        if (r < 20)
            send_request(tdse_pkg::OP_PUSH, random_payload(), t, 1'($urandom));
        else if (r < 40)
            indexed_access();
        else if (r < 73)
            send_request(5'($urandom_range(tdse_pkg::OP_DUP, tdse_pkg::OP_TUCK)),
                         random_payload(), t, 1'($urandom));
        else if (r < 88)
            send_request($urandom_range(0, 1) ? tdse_pkg::OP_DROP : tdse_pkg::OP_DROP2,
                         random_payload(), t, 1'($urandom));
        else if (r < 91)
            send_request($urandom_range(0, 1) ? tdse_pkg::OP_PICK : tdse_pkg::OP_ROLL,
                         random_payload(), t, 1'($urandom));
        else if (r < 94)
            send_request(tdse_pkg::OP_DEPTH, random_payload(), t, 1'($urandom));
        else if (r < 96)
            send_request(tdse_pkg::OP_CLEAR, random_payload(), t, 1'($urandom));
        else if (r < 98)
            send_request(5'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST)),
                         random_payload(), t, 1'($urandom));
        else
            send_request(tdse_pkg::OP_NIP, random_payload(), t, 1'($urandom));
    endtask

    // Grow past the limit, then walk deep entries with roll and pick.
    task automatic fill_to_overflow();
        int r;
        repeat (STACK_DEPTH + 6)
        begin
            r = $urandom_range(0, 9);
            if (r < 8)
                send_request(tdse_pkg::OP_PUSH, random_payload(), 2'($urandom_range(0, 3)),
                             1'($urandom));
            else if (r == 8)
                send_request(tdse_pkg::OP_DEPTH, random_payload(), 2'($urandom),
                             1'($urandom));
            else
                send_request($urandom_range(0, 1) ? tdse_pkg::OP_DUP : tdse_pkg::OP_OVER2,
                             random_payload(), 2'($urandom), 1'($urandom));
        end
        send_request(tdse_pkg::OP_DUP2, random_payload(), 2'($urandom), 1'($urandom));
        send_request(tdse_pkg::OP_DROP, random_payload(), 2'($urandom), 1'($urandom));
        send_request(tdse_pkg::OP_PUSH, 64'(STACK_DEPTH - 2), 2'd0, 1'($urandom));
        send_request(tdse_pkg::OP_ROLL, random_payload(), 2'($urandom), 1'($urandom));
        send_request(tdse_pkg::OP_PUSH, 64'(STACK_DEPTH - 2), 2'd0, 1'($urandom));
        send_request(tdse_pkg::OP_PICK, random_payload(), 2'($urandom), 1'($urandom));
        send_request(tdse_pkg::OP_PUSH, 64'(STACK_DEPTH - 2), 2'd0, 1'($urandom));
        send_request(tdse_pkg::OP_CLEAR, random_payload(), 2'($urandom), 1'($urandom));
    endtask

    initial
    begin : stimulus
        int next_fill;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        operation  = tdse_pkg::OP_PUSH;
        push_value = '0;
        push_tag   = 2'd0;
        push_taint = 1'b0;
        requests_sent = 0;
        burst_left    = 0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // empty-stack cases, field extremes, every shuffle, index errors
        send_request(tdse_pkg::OP_DROP, '0, 2'd0, 1'b0);
        send_request(tdse_pkg::OP_CLEAR, '1, 2'd3, 1'b1);
        send_request(tdse_pkg::OP_PUSH, 64'h7FFF_FFFF_FFFF_FFFF, 2'd0, 1'b1);
        send_request(tdse_pkg::OP_PUSH, 64'h8000_0000_0000_0000, 2'd1, 1'b0);
        send_request(tdse_pkg::OP_PUSH, 64'd0, 2'd2, 1'b1);
        send_request(tdse_pkg::OP_PUSH, '1, 2'd3, 1'b0);
        send_request(tdse_pkg::OP_PICK, '0, 2'd0, 1'b0);
        send_request(tdse_pkg::OP_DEPTH, '1, 2'd3, 1'b1);
        send_request(tdse_pkg::OP_DUP, '0, 2'd0, 1'b0);
        send_request(tdse_pkg::OP_DUPD, '0, 2'd0, 1'b0);
        send_request(tdse_pkg::OP_DUP2, '0, 2'd0, 1'b0);
        send_request(tdse_pkg::OP_SWAP, '0, 2'd0, 1'b0);
        send_request(tdse_pkg::OP_SWAPD, '0, 2'd0, 1'b0);
        send_request(tdse_pkg::OP_SWAP2, '0, 2'd0, 1'b0);
        send_request(tdse_pkg::OP_OVER, '0, 2'd0, 1'b0);
        send_request(tdse_pkg::OP_OVERD, '0, 2'd0, 1'b0);
        send_request(tdse_pkg::OP_OVER2, '0, 2'd0, 1'b0);
        send_request(tdse_pkg::OP_NIP, '0, 2'd0, 1'b0);
        send_request(tdse_pkg::OP_NIPD, '0, 2'd0, 1'b0);
        send_request(tdse_pkg::OP_DROP2, '0, 2'd0, 1'b0);
        send_request(tdse_pkg::OP_ROT, '0, 2'd0, 1'b0);
        send_request(tdse_pkg::OP_TUCK, '0, 2'd0, 1'b0);
        send_request(tdse_pkg::OP_PUSH, '1, 2'd0, 1'b0);
        send_request(tdse_pkg::OP_ROLL, '0, 2'd0, 1'b0);
        send_request(tdse_pkg::OP_PUSH, 64'd0, 2'd0, 1'b0);
        send_request(tdse_pkg::OP_ROLL, '0, 2'd0, 1'b0);
        send_request(OP_UNUSED_LAST, '1, 2'd3, 1'b1);
        pause_until_drained();

        next_fill = requests_sent + FILL_SPACING / 2;
        while (requests_sent < ITEM_TARGET)
        begin
            if (requests_sent >= next_fill)
            begin
                fill_to_overflow();
                pause_until_drained();
                next_fill += FILL_SPACING;
            end
            churn_step();
        end

        pause_until_drained();
        repeat (40) @(negedge clk);
        if (mismatch_count == 0 && pending_results == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
